// ----- hdl/fslv_pkg.sv -----
// ----------------------------------------------------------------------------
// fslv_pkg
// Shared types, codes and constants for the flash slot log value store.
// ----------------------------------------------------------------------------
package fslv_pkg;

    localparam int          SLOT_COUNT_DEF = 256;
    localparam logic [31:0] MARKER_RESET   = 32'h4E56_4D01;
    localparam logic [31:0] ERASED_WORD    = 32'hFFFF_FFFF;

    // function codes
    localparam logic [1:0] FUNC_RELOAD = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_RAW    = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SKIPPED   = 3'd1;
    localparam logic [2:0] ST_PROG_FAIL = 3'd2;
    localparam logic [2:0] ST_NO_VALID  = 3'd3;
    localparam logic [2:0] ST_RAW       = 3'd4;

    // scan address operations
    localparam logic [2:0] ADDR_HOLD = 3'd0;
    localparam logic [2:0] ADDR_ZERO = 3'd1;
    localparam logic [2:0] ADDR_LAST = 3'd2;
    localparam logic [2:0] ADDR_UP   = 3'd3;
    localparam logic [2:0] ADDR_DOWN = 3'd4;

    // memory write operations
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_ERASE = 2'd1;
    localparam logic [1:0] MEM_PROG  = 2'd2;
    localparam logic [1:0] MEM_RAW   = 2'd3;

    // result register updates
    localparam logic [2:0] RES_NONE      = 3'd0;
    localparam logic [2:0] RES_SKIP      = 3'd1;
    localparam logic [2:0] RES_RL_HIT    = 3'd2;
    localparam logic [2:0] RES_RL_MISS   = 3'd3;
    localparam logic [2:0] RES_RAW       = 3'd4;
    localparam logic [2:0] RES_TGT_HIT   = 3'd5;
    localparam logic [2:0] RES_TGT_ERASE = 3'd6;
    localparam logic [2:0] RES_PROG      = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] value;
        logic [7:0]  slot_index;
        logic [63:0] raw_word;
        logic        program_ok;
    } t_item;

    typedef struct packed {
        logic [31:0] stored_value;
        logic [7:0]  slot_used;
        logic        page_erased;
        logic [2:0]  status;
    } t_result;

    typedef struct packed {
        logic       capture;
        logic       scan;
        logic [2:0] addr_op;
        logic [1:0] mem_op;
        logic [2:0] res_op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       same_value;
        logic       rl_hit;
        logic       rl_stop;
        logic       wr_hit;
        logic       wr_last;
        logic       addr_last;
    } t_sts;

endpackage

// ----- hdl/flash_slot_log_value_store.sv -----
// ----------------------------------------------------------------------------
// flash_slot_log_value_store
// One-page slot log holding a single 32-bit value with marker-tagged slots.
// ----------------------------------------------------------------------------
//  channel   signals                          handshake
//  item      start, busy, i_item              taken when start & !busy
//  result    o_done, o_result                 one-cycle strobe, no backpressure
//  config    i_cfg_valid, o_cfg_ready, data   taken when valid & ready
//
//  Slot memory has one read and one write port; scans read one slot per cycle.
//  Reload scans down from the last slot; raw-load and skipped write need no scan.
//  Write scans up for an erased slot and erases the page when none is left.
//  After reset a clearing pass erases the page; busy is high during it,
//  configuration writes are still taken.
//  Results cannot be stalled; o_done is high for one cycle per item.
// ----------------------------------------------------------------------------
module flash_slot_log_value_store #(
    parameter int SLOT_COUNT = fslv_pkg::SLOT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  fslv_pkg::t_item    i_item,
    output logic               o_done,
    output fslv_pkg::t_result  o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import fslv_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    fslv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fslv_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_result)
    );

endmodule

// ----- hdl/fslv_ctrl.sv -----
// ----------------------------------------------------------------------------
// fslv_ctrl
// Sequencer: clearing pass, dispatch, slot scans, page erase, program, result.
// ----------------------------------------------------------------------------
module fslv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    input  fslv_pkg::t_sts i_sts,
    output fslv_pkg::t_cmd o_cmd
);
    import fslv_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_RL_SCAN  = 4'd3;
    localparam logic [3:0] S_WR_SCAN  = 4'd4;
    localparam logic [3:0] S_ERASE    = 4'd5;
    localparam logic [3:0] S_PROG     = 4'd6;
    localparam logic [3:0] S_DONE     = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.addr_op = ADDR_HOLD;
        o_cmd.mem_op  = MEM_NONE;
        o_cmd.res_op  = RES_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.mem_op  = MEM_ERASE;
                o_cmd.addr_op = ADDR_UP;
                if (i_sts.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.func)
                    FUNC_RELOAD: begin
                        o_cmd.addr_op = ADDR_LAST;
                        n_state       = S_RL_SCAN;
                    end
                    FUNC_WRITE: begin
                        if (i_sts.same_value) begin
                            o_cmd.res_op = RES_SKIP;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.addr_op = ADDR_ZERO;
                            n_state       = S_WR_SCAN;
                        end
                    end
                    FUNC_RAW: begin
                        o_cmd.mem_op = MEM_RAW;
                        o_cmd.res_op = RES_RAW;
                        n_state      = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RL_SCAN: begin
                // one read issued per cycle, check uses the registered read of the previous address
                o_cmd.scan    = 1'b1;
                o_cmd.addr_op = ADDR_DOWN;
                if (i_sts.rl_hit) begin
                    o_cmd.res_op = RES_RL_HIT;
                    n_state      = S_DONE;
                end else if (i_sts.rl_stop) begin
                    o_cmd.res_op = RES_RL_MISS;
                    n_state      = S_DONE;
                end
            end
            S_WR_SCAN: begin
                o_cmd.scan    = 1'b1;
                o_cmd.addr_op = ADDR_UP;
                if (i_sts.wr_hit) begin
                    o_cmd.res_op = RES_TGT_HIT;
                    n_state      = S_PROG;
                end else if (i_sts.wr_last) begin
                    o_cmd.res_op  = RES_TGT_ERASE;
                    o_cmd.addr_op = ADDR_ZERO;
                    n_state       = S_ERASE;
                end
            end
            S_ERASE: begin
                o_cmd.mem_op  = MEM_ERASE;
                o_cmd.addr_op = ADDR_UP;
                if (i_sts.addr_last) begin
                    n_state = S_PROG;
                end
            end
            S_PROG: begin
                o_cmd.mem_op = MEM_PROG;
                o_cmd.res_op = RES_PROG;
                n_state      = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// ----- hdl/fslv_dp.sv -----
// ----------------------------------------------------------------------------
// fslv_dp
// Datapath: slot memory, scan address, marker compare, cache and result regs.
// ----------------------------------------------------------------------------
module fslv_dp #(
    parameter int SLOT_COUNT = fslv_pkg::SLOT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fslv_pkg::t_item    i_item,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    input  fslv_pkg::t_cmd     i_cmd,
    output fslv_pkg::t_sts     o_sts,
    output fslv_pkg::t_result  o_result
);
    import fslv_pkg::*;

    localparam int AW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WIDE = (AW + 1 > 9) ? AW + 1 : 9;
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

    logic [63:0]   r_mem [SLOT_COUNT];
    logic [63:0]   r_rdata;
    logic [AW-1:0] r_rd_addr;
    logic          r_rd_vld;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] n_addr;
    logic [AW-1:0] r_tgt;
    t_item         r_item;
    logic [31:0]   r_marker;
    logic [31:0]   r_cache;
    logic [7:0]    r_slot;
    logic          r_erased;
    logic [2:0]    r_status;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [63:0]   mem_wd;
    logic [WIDE-1:0] rd_addr_ext;
    logic [WIDE-1:0] sidx_ext;
    logic            sidx_ok;
    logic [31:0]     rd_marker;

    assign rd_addr_ext = WIDE'(r_rd_addr);
    assign sidx_ext    = WIDE'(r_item.slot_index);
    assign sidx_ok     = (sidx_ext < WIDE'(SLOT_COUNT));
    assign rd_marker   = r_rdata[31:0];

    always_comb begin
        case (i_cmd.addr_op)
            ADDR_ZERO: n_addr = '0;
            ADDR_LAST: n_addr = LAST;
            ADDR_UP:   n_addr = r_addr + AW'(1);
            ADDR_DOWN: n_addr = r_addr - AW'(1);
            default:   n_addr = r_addr;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '1;
        case (i_cmd.mem_op)
            MEM_ERASE: begin
                mem_we = 1'b1;
            end
            MEM_PROG: begin
                mem_we = r_item.program_ok;
                mem_wa = r_tgt;
                mem_wd = {r_item.value, r_marker};
            end
            MEM_RAW: begin
                mem_we = sidx_ok;
                mem_wa = sidx_ext[AW-1:0];
                mem_wd = r_item.raw_word;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata   <= r_mem[r_addr];
        r_rd_addr <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_marker <= MARKER_RESET;
            r_cache  <= '0;
        end else begin
            r_addr   <= n_addr;
            r_rd_vld <= i_cmd.scan;
            if (i_cfg_we) begin
                r_marker <= i_cfg_data;
            end
            case (i_cmd.res_op)
                RES_RL_HIT:  r_cache <= r_rdata[63:32];
                RES_RL_MISS: r_cache <= '0;
                RES_PROG: begin
                    if (r_item.program_ok) begin
                        r_cache <= r_item.value;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and per-item result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item   <= i_item;
            r_slot   <= '0;
            r_erased <= 1'b0;
            r_status <= ST_OK;
        end else begin
            case (i_cmd.res_op)
                RES_SKIP: r_status <= ST_SKIPPED;
                RES_RL_HIT: r_slot <= rd_addr_ext[7:0];
                RES_RL_MISS: r_status <= ST_NO_VALID;
                RES_RAW: begin
                    r_slot   <= r_item.slot_index;
                    r_status <= ST_RAW;
                end
                RES_TGT_HIT: begin
                    r_tgt  <= r_rd_addr;
                    r_slot <= rd_addr_ext[7:0];
                end
                RES_TGT_ERASE: begin
                    r_tgt    <= '0;
                    r_erased <= 1'b1;
                end
                RES_PROG: begin
                    if (!r_item.program_ok) begin
                        r_status <= ST_PROG_FAIL;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.func       = r_item.func;
    assign o_sts.same_value = (r_item.value == r_cache);
    assign o_sts.rl_hit     = r_rd_vld && (rd_marker == r_marker);
    assign o_sts.rl_stop    = r_rd_vld && ((rd_marker != ERASED_WORD) || (r_rd_addr == '0));
    assign o_sts.wr_hit     = r_rd_vld && (rd_marker == ERASED_WORD);
    assign o_sts.wr_last    = r_rd_vld && (r_rd_addr == LAST);
    assign o_sts.addr_last  = (r_addr == LAST);

    assign o_result.stored_value = r_cache;
    assign o_result.slot_used    = r_slot;
    assign o_result.page_erased  = r_erased;
    assign o_result.status       = r_status;

endmodule

// ----- hdl/fslv_chk.sv -----
// ----------------------------------------------------------------------------
// fslv_chk
// Port-level checks for the flash slot log value store.
// ----------------------------------------------------------------------------
module fslv_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input fslv_pkg::t_result o_result
);
    import fslv_pkg::*;

    // an accepted transaction keeps the block busy until its result
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after accepted transaction");

    // a result strobe ends the transaction: block free on the next cycle
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("block not idle after result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status <= ST_RAW))
        else $error("status code out of range");

    // only a write that reached programming can report an erased page
    a_erase_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.page_erased) |->
            ((o_result.status == ST_OK) || (o_result.status == ST_PROG_FAIL)))
        else $error("page erase reported on wrong status");

    a_skip_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_SKIPPED)) |->
            ((o_result.slot_used == 8'd0) && !o_result.page_erased))
        else $error("skipped write reports slot or erase");

endmodule

bind flash_slot_log_value_store fslv_chk u_fslv_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ----- bench/fslv_log_checker.sv -----
// ----------------------------------------------------------------------------
// fslv_log_checker
// Watches the item, result and marker channels of the slot log value store,
// keeps its own copy of the page, cached value and valid marker, predicts
// each result at item acceptance and compares the strobed results in order.
// ----------------------------------------------------------------------------
module fslv_log_checker #(
    parameter int SLOTS = fslv_pkg::SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  fslv_pkg::t_item   i_item,
    input  logic              i_done,
    input  fslv_pkg::t_result i_result,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [31:0]       i_cfg_data,
    output int                o_fail_count,
    output int                o_open_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import fslv_pkg::*;

    logic [63:0] log_slots [SLOTS];
    logic [31:0] cached_value;
    logic [31:0] valid_marker;
    t_result     awaited_results [$];
    int          mismatches = 0;

    // Applies one item to the local page copy and returns the result it gives.
    function automatic t_result next_store_result(input t_item it);
        t_result r;
        int      k;
        bit      hit;
        r   = '0;
        hit = 1'b0;
        r.status = ST_OK;
        case (it.func)
            FUNC_RELOAD: begin
                // backward scan: erased slots are skipped, anything else stops it
                for (k = SLOTS - 1; k >= 0; k--) begin
                    if (log_slots[k][31:0] == valid_marker) begin
                        hit = 1'b1;
                        break;
                    end
                    if (log_slots[k][31:0] != ERASED_WORD)
                        break;
                end
                if (hit) begin
                    cached_value = log_slots[k][63:32];
                    r.slot_used  = 8'(k);
                end else begin
                    cached_value = '0;
                    r.status     = ST_NO_VALID;
                end
            end
            FUNC_WRITE: begin
                if (it.value == cached_value) begin
                    r.status = ST_SKIPPED;
                end else begin
                    k = 0;
                    while (k < SLOTS && log_slots[k][31:0] != ERASED_WORD)
                        k++;
                    if (k == SLOTS) begin
                        foreach (log_slots[j])
                            log_slots[j] = '1;
                        r.page_erased = 1'b1;
                        k = 0;
                    end
                    r.slot_used = 8'(k);
                    if (it.program_ok) begin
                        log_slots[k] = {it.value, valid_marker};
                        cached_value = it.value;
                    end else begin
                        r.status = ST_PROG_FAIL;
                    end
                end
            end
            FUNC_RAW: begin
                if (int'(it.slot_index) < SLOTS)
                    log_slots[it.slot_index] = it.raw_word;
                r.slot_used = it.slot_index;
                r.status    = ST_RAW;
            end
            default: ;
        endcase
        r.stored_value = cached_value;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (log_slots[j])
                log_slots[j] = '1;
            cached_value = '0;
            valid_marker = MARKER_RESET;
            awaited_results.delete();
        end else begin
            // results first: a result at this edge belongs to an earlier item
            if (i_done === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: unexpected result value=%h slot=%0d erased=%b status=%0d",
                                 $realtime, i_result.stored_value, i_result.slot_used,
                                 i_result.page_erased, i_result.status);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result.stored_value !== want.stored_value ||
                        i_result.slot_used !== want.slot_used ||
                        i_result.page_erased !== want.page_erased ||
                        i_result.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%t: result mismatch exp value=%h slot=%0d erased=%b ",
                                      "status=%0d got value=%h slot=%0d erased=%b status=%0d"},
                                     $realtime, want.stored_value, want.slot_used,
                                     want.page_erased, want.status, i_result.stored_value,
                                     i_result.slot_used, i_result.page_erased,
                                     i_result.status);
                    end
                end
            end
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1)
                valid_marker = i_cfg_data;
            if (i_start === 1'b1 && i_busy === 1'b0)
                awaited_results.push_back(next_store_result(i_item));
        end
        o_open_count <= awaited_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- bench/flash_slot_log_value_store_tb.sv -----
// ----------------------------------------------------------------------------
// flash_slot_log_value_store_tb
// Drives reloads, writes, raw slot presets and the unused code into the slot
// log store under several valid markers, with random gaps and drains; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module flash_slot_log_value_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fslv_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         LOG_SLOTS   = SLOT_COUNT_DEF;
    localparam int         CALM_FIRST  = 600;
    localparam int         CALM_LAST   = 800;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    t_item       i_item      = '0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data  = '0;
    logic        busy;
    logic        o_done;
    logic        o_cfg_ready;
    t_result     o_result;
    int          fail_count;
    int          open_count;

    logic [31:0] marker_now = MARKER_RESET;
    logic [31:0] last_value = '0;
    int          sent       = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    flash_slot_log_value_store #(
        .SLOT_COUNT (LOG_SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    fslv_log_checker #(
        .SLOTS (LOG_SLOTS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    // start stays high on return; the caller decides whether to drop it
    task automatic send(input t_item it);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        sent++;
        if (it.func == FUNC_WRITE)
            last_value = it.value;
    endtask

    task automatic maybe_idle();
        int n;
        if (sent >= CALM_FIRST && sent < CALM_LAST)
            return;
        if ($urandom_range(99) < 22) begin
            start <= 1'b0;
            n = ($urandom_range(9) == 0) ? $urandom_range(300, 40) : $urandom_range(8, 1);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // open_count is registered, so always step at least once
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0)
            @(posedge i_clk);
    endtask

    task automatic write_marker(input logic [31:0] m);
        drain();
        if ($urandom_range(99) < 22)
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        marker_now = m;
    endtask

    task automatic issue(input logic [1:0] f, input logic [31:0] v, input logic [7:0] s,
                         input logic [63:0] w, input logic ok);
        t_item it;
        it.func       = f;
        it.value      = v;
        it.slot_index = s;
        it.raw_word   = w;
        it.program_ok = ok;
        maybe_idle();
        send(it);
    endtask

    // mostly writes that walk the page, plus presets aimed at the scan ends
    function automatic t_item random_item();
        t_item it;
        int    roll;
        roll          = $urandom_range(99);
        it.value      = $urandom;
        it.slot_index = 8'($urandom);
        it.raw_word   = {$urandom, $urandom};
        it.program_ok = ($urandom_range(99) < 85);
        if (roll < 55) begin
            it.func = FUNC_WRITE;
            if ($urandom_range(99) < 15)
                it.value = last_value;
        end else if (roll < 75) begin
            it.func = FUNC_RELOAD;
        end else if (roll < 95) begin
            it.func = FUNC_RAW;
            case ($urandom_range(3))
                0: it.slot_index = 8'($urandom_range(LOG_SLOTS - 1, LOG_SLOTS - 16));
                1: it.slot_index = 8'($urandom_range(15));
                default: ;
            endcase
            roll = $urandom_range(99);
            if (roll < 40)
                it.raw_word[31:0] = marker_now;
            else if (roll < 70)
                it.raw_word[31:0] = ERASED_WORD;
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    task automatic run_random(input int n);
        repeat (n) begin
            maybe_idle();
            if ($urandom_range(99) == 0)
                drain();
            send(random_item());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // taken during the clearing pass
        write_marker(MARKER_RESET);

        issue(FUNC_RELOAD, '0, '0, '0, 1'b1);                          // erased page
        issue(FUNC_WRITE, 32'h0000_0000, '0, '0, 1'b1);                // equals cache
        issue(FUNC_WRITE, 32'hFFFF_FFFF, '0, '0, 1'b1);
        issue(FUNC_WRITE, 32'h1234_5678, '0, '0, 1'b0);                // program fails
        issue(FUNC_WRITE, 32'h1234_5678, '0, '0, 1'b1);
        issue(FUNC_RELOAD, '0, '0, '0, 1'b0);
        issue(FUNC_RAW, '0, 8'd255, {32'hA5A5_A5A5, marker_now}, 1'b0);
        issue(FUNC_RELOAD, '0, '0, '0, 1'b1);                          // hit at last slot
        issue(FUNC_WRITE, 32'hA5A5_A5A5, '0, '0, 1'b1);
        issue(FUNC_RAW, '0, 8'd255, 64'h0, 1'b1);
        issue(FUNC_RELOAD, '0, '0, '0, 1'b1);                          // stopped by junk
        issue(FUNC_RAW, '0, 8'd255, '1, 1'b0);
        issue(FUNC_RAW, '0, 8'd0, 64'h0, 1'b0);
        issue(FUNC_RAW, '0, 8'd128, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        issue(FUNC_RELOAD, '0, '0, '0, 1'b0);
        issue(FUNC_RAW, '0, 8'd128, '1, 1'b1);
        issue(FUNC_RELOAD, '0, '0, '0, 1'b1);                          // skips to slot 1
        issue(FUNC_UNUSED, '1, '1, '1, 1'b1);
        issue(FUNC_WRITE, 32'h0000_0001, '1, '1, 1'b1);

        run_random(400);
        write_marker(ERASED_WORD);
        run_random(250);
        write_marker(32'h0000_0000);
        run_random(250);
        write_marker($urandom);
        run_random(250);
        write_marker(MARKER_RESET);
        run_random(150);

        drain();
        repeat (2 * LOG_SLOTS + 8) @(posedge i_clk);
        if (fail_count == 0 && open_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
